@@ rtl/fsi_pkg.sv @@
// ----------------------------------------------------------------------------
// fsi_pkg
// Types, constants and the rule label table of the fuzzy speed inference unit.
// ----------------------------------------------------------------------------
package fsi_pkg;

    localparam int IN_W     = 11;
    localparam int SPEED_W  = 9;
    localparam int LEVELS   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int RULES    = 8;
    localparam int GRADE_W  = 7;
    localparam int LABEL_W  = 3;
    localparam int SEG_W    = 3;
    localparam int SCALE_W  = 7;
    localparam int PRE_W    = 10;
    localparam int PROD_W   = GRADE_W + SPEED_W;
    localparam int DEN_W    = 10;
    localparam int NUM_W    = 19;
    localparam int QBITS    = SPEED_W;

    // stage map: clamp, scale, membership, rules, 4 x elimination,
    // products, sums, then one stage per quotient bit
    localparam int ST_CLAMP = 0;
    localparam int ST_SCALE = 1;
    localparam int ST_MEMB  = 2;
    localparam int ST_RULE  = 3;
    localparam int ST_ELIM  = 4;
    localparam int ELIM_ST  = 4;
    localparam int ST_PROD  = ST_ELIM + ELIM_ST;
    localparam int ST_SUM   = ST_PROD + 1;
    localparam int ST_DIV   = ST_SUM + 1;
    localparam int NUM_ST   = ST_DIV + QBITS;

    // ceil(2^16 / 9), exact floor for values below 2^15
    localparam int RECIP9   = 7282;

    localparam logic [SPEED_W-1:0] LEVEL_RST [LEVELS] =
        '{9'd220, 9'd235, 9'd240, 9'd255, 9'd275, 9'd305, 9'd340};

    typedef logic [0:6][LABEL_W-1:0] t_lrow;
    typedef logic [5:0] t_lidx;

    // row index is complexity label * 7 + lookahead label
    function automatic t_lrow f_label_row(input t_lidx idx);
        t_lrow r;
        case (idx)
            6'd0:  r = {3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd1};
            6'd1:  r = {3'd5,3'd5,3'd4,3'd3,3'd2,3'd1,3'd1};
            6'd2:  r = {3'd4,3'd4,3'd3,3'd2,3'd1,3'd1,3'd0};
            6'd3:  r = {3'd3,3'd3,3'd3,3'd2,3'd1,3'd1,3'd0};
            6'd4:  r = {3'd2,3'd2,3'd2,3'd1,3'd1,3'd0,3'd0};
            6'd5:  r = {3'd2,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0};
            6'd6:  r = {3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd7:  r = {3'd5,3'd4,3'd3,3'd2,3'd1,3'd1,3'd1};
            6'd8:  r = {3'd4,3'd4,3'd3,3'd2,3'd1,3'd1,3'd0};
            6'd9:  r = {3'd3,3'd3,3'd2,3'd1,3'd1,3'd0,3'd0};
            6'd10: r = {3'd2,3'd2,3'd2,3'd1,3'd0,3'd0,3'd0};
            6'd11: r = {3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0};
            6'd12: r = {3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd13: r = {3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd14: r = {3'd4,3'd3,3'd2,3'd1,3'd1,3'd1,3'd0};
            6'd15: r = {3'd3,3'd3,3'd2,3'd1,3'd1,3'd0,3'd0};
            6'd16: r = {3'd2,3'd2,3'd1,3'd1,3'd0,3'd0,3'd0};
            6'd17: r = {3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0};
            6'd18: r = {3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd19: r = {3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd21: r = {3'd3,3'd2,3'd1,3'd1,3'd1,3'd0,3'd0};
            6'd22: r = {3'd2,3'd2,3'd1,3'd1,3'd0,3'd0,3'd0};
            6'd23: r = {3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0};
            6'd24: r = {3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd25: r = {3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd28: r = {3'd2,3'd1,3'd1,3'd1,3'd0,3'd0,3'd0};
            6'd29: r = {3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0};
            6'd30: r = {3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd31: r = {3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd35: r = {3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0};
            6'd36: r = {3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd37: r = {3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd42: r = {3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0};
            6'd43: r = {3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/fsi_in_if.sv @@
// ----------------------------------------------------------------------------
// fsi_in_if
// Input channel: three track measures with valid/ready.
// ----------------------------------------------------------------------------
interface fsi_in_if import fsi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [IN_W-1:0]   complexity;
    logic signed [IN_W-1:0]   lookahead;
    logic signed [IN_W-1:0]   third_measure;

    modport source (output valid, complexity, lookahead, third_measure, input ready);
    modport sink   (input valid, complexity, lookahead, third_measure, output ready);
endinterface

@@ rtl/fsi_out_if.sv @@
// ----------------------------------------------------------------------------
// fsi_out_if
// Output channel: inferred speed with valid/ready.
// ----------------------------------------------------------------------------
interface fsi_out_if import fsi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed;

    modport source (output valid, speed, input ready);
    modport sink   (input valid, speed, output ready);
endinterface

@@ rtl/fuzzy_speed_inference_unit.sv @@
// ----------------------------------------------------------------------------
// fuzzy_speed_inference_unit
// Three-input fuzzy inference: scale, memberships, rule table, same-label
// elimination and a weighted average through a pipelined divider.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   transfer when
//  i_in      in   complexity, lookahead, third_measure      valid & ready
//  o_out     out  speed                                     valid & ready
//  cfg       in   i_cfg_idx, i_cfg_data                     i_cfg_we
//
//  One item per cycle while o_out is not stalled; the divider resolves one
//  quotient bit per stage, most significant bit first.
//  Synchronous active-low reset clears the valid bits and loads the default
//  speed levels.
//  A stall on o_out fills empty stages first; ready drops only when every
//  stage holds an item.
// ----------------------------------------------------------------------------
module fuzzy_speed_inference_unit import fsi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fsi_in_if.sink                i_in,
    fsi_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SPEED_W-1:0]    i_cfg_data
);

    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST:0]   rdy;
    logic [SPEED_W-1:0] r_level [LEVELS];

    // stage payloads
    logic [PRE_W-1:0]   r_pre   [3];
    logic [SCALE_W-1:0] r_x     [3];
    logic [SEG_W-1:0]   r_seg   [3];
    logic [GRADE_W-1:0] r_g0    [3];
    logic [LABEL_W-1:0] r_lab   [RULES];
    logic [GRADE_W-1:0] r_w     [RULES];
    logic [LABEL_W-1:0] r_el_lab [ELIM_ST][RULES];
    logic [GRADE_W-1:0] r_el_w   [ELIM_ST][RULES];
    logic [PROD_W-1:0]  r_prod  [RULES];
    logic [DEN_W-1:0]   r_den8;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_dv_rem [QBITS];
    logic [QBITS-1:0]   r_dv_q   [QBITS];
    logic [DEN_W-1:0]   r_dv_den [QBITS];

    // ---------------------------------------------------------------- control
    always_comb begin
        rdy[NUM_ST] = o_out.ready;
        for (int k = NUM_ST - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign i_in.ready  = rdy[0];
    assign o_out.valid = r_vld[NUM_ST-1];
    assign o_out.speed = (r_dv_den[QBITS-1] == '0) ? '0 : r_dv_q[QBITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_ST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVELS; k++) begin
                r_level[k] <= LEVEL_RST[k];
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(LEVELS))) begin
            r_level[i_cfg_idx] <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------- clamp
    logic [PRE_W-1:0] n_pre [3];

    always_comb begin
        logic signed [IN_W:0]   dc, dt;
        logic signed [IN_W-1:0] dl;
        logic [8:0]             uc, ut;
        logic [5:0]             ul;
        // widen by one bit so the offset never wraps
        dc = {i_in.complexity[IN_W-1], i_in.complexity} - 12'sd20;
        dl = i_in.lookahead;
        dt = {i_in.third_measure[IN_W-1], i_in.third_measure} - 12'sd50;
        if (dc < 0)              uc = '0;
        else if (dc > 12'sd180)  uc = 9'd180;
        else                     uc = dc[8:0];
        if (dl < 0)              ul = '0;
        else if (dl > 11'sd50)   ul = 6'd50;
        else                     ul = dl[5:0];
        if (dt < 0)              ut = '0;
        else if (dt > 12'sd450)  ut = 9'd450;
        else                     ut = dt[8:0];
        n_pre[0] = PRE_W'({1'b0, uc} * 10'd5);
        n_pre[1] = PRE_W'({ul, 1'b0});
        n_pre[2] = PRE_W'({ut, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_CLAMP]) begin
            r_pre <= n_pre;
        end
    end

    // ---------------------------------------------------------------- scale
    localparam int MW = PRE_W + 14;

    logic [MW-1:0] prod_c, prod_t;

    assign prod_c = MW'(r_pre[0]) * MW'(RECIP9);
    assign prod_t = MW'(r_pre[2]) * MW'(RECIP9);

    always_ff @(posedge i_clk) begin
        if (rdy[ST_SCALE]) begin
            r_x[0] <= prod_c[16 +: SCALE_W];
            r_x[1] <= r_pre[1][SCALE_W-1:0];
            r_x[2] <= prod_t[16 +: SCALE_W];
        end
    end

    // ----------------------------------------------------------- membership
    always_ff @(posedge i_clk) begin
        if (rdy[ST_MEMB]) begin
            for (int m = 0; m < 3; m++) begin
                logic [SCALE_W-1:0] kk;
                logic [SCALE_W-1:0] df;
                logic [10:0]        pg;
                kk = (r_x[m] + 7'd15) >> 4;
                df = {kk[2:0], 4'b0} - r_x[m];
                pg = 11'(df) * 11'd100;
                if (r_x[m] == '0) begin
                    r_seg[m] <= 3'd1;
                    r_g0[m]  <= 7'd100;
                end else if (r_x[m] >= 7'd96) begin
                    r_seg[m] <= 3'd6;
                    r_g0[m]  <= '0;
                end else begin
                    r_seg[m] <= kk[SEG_W-1:0];
                    r_g0[m]  <= pg[10:4];
                end
            end
        end
    end

    // ---------------------------------------------------------------- rules
    logic [LABEL_W-1:0] n_lab [RULES];
    logic [GRADE_W-1:0] n_w   [RULES];

    always_comb begin
        for (int i = 0; i < RULES; i++) begin
            logic [SEG_W-1:0]   a, b, c;
            logic [GRADE_W-1:0] ga, gb, gc, mn;
            t_lrow              row;
            a  = r_seg[0] - 3'd1 + SEG_W'(i[0]);
            b  = r_seg[1] - 3'd1 + SEG_W'(i[1]);
            c  = r_seg[2] - 3'd1 + SEG_W'(i[2]);
            ga = i[0] ? 7'd100 - r_g0[0] : r_g0[0];
            gb = i[1] ? 7'd100 - r_g0[1] : r_g0[1];
            gc = i[2] ? 7'd100 - r_g0[2] : r_g0[2];
            row = f_label_row(t_lidx'(a) * t_lidx'(7) + t_lidx'(b));
            n_lab[i] = (c < 3'd7) ? row[c] : '0;
            mn = (ga < gb) ? ga : gb;
            n_w[i] = (mn < gc) ? mn : gc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_RULE]) begin
            r_lab <= n_lab;
            r_w   <= n_w;
        end
    end

    // ---------------------------------------------- same-label elimination
    // each stage runs two outer rule indexes of the pairwise sweep
    for (genvar s = 0; s < ELIM_ST; s++) begin : g_elim
        logic [LABEL_W-1:0] lab_in [RULES];
        logic [GRADE_W-1:0] w_in   [RULES];
        logic [GRADE_W-1:0] w_out  [RULES];

        if (s == 0) begin : g_first
            assign lab_in = r_lab;
            assign w_in   = r_w;
        end else begin : g_next
            assign lab_in = r_el_lab[s-1];
            assign w_in   = r_el_w[s-1];
        end

        always_comb begin
            w_out = w_in;
            for (int ii = 2 * s; ii < 2 * s + 2; ii++) begin
                for (int j = ii + 1; j < RULES; j++) begin
                    if (lab_in[ii] == lab_in[j]) begin
                        if (w_out[ii] > w_out[j]) w_out[j]  = '0;
                        else                      w_out[ii] = '0;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[ST_ELIM+s]) begin
                r_el_lab[s] <= lab_in;
                r_el_w[s]   <= w_out;
            end
        end
    end

    // ------------------------------------------------------------- products
    always_ff @(posedge i_clk) begin
        if (rdy[ST_PROD]) begin
            logic [DEN_W-1:0] d;
            d = '0;
            for (int i = 0; i < RULES; i++) begin
                logic [LABEL_W-1:0] lb;
                lb = r_el_lab[ELIM_ST-1][i];
                r_prod[i] <= PROD_W'(r_el_w[ELIM_ST-1][i])
                           * PROD_W'(r_level[(lb < 3'd7) ? lb : 3'd0]);
                d = d + DEN_W'(r_el_w[ELIM_ST-1][i]);
            end
            r_den8 <= d;
        end
    end

    // ----------------------------------------------------------------- sums
    always_ff @(posedge i_clk) begin
        if (rdy[ST_SUM]) begin
            logic [NUM_W-1:0] sm;
            sm = '0;
            for (int i = 0; i < RULES; i++) begin
                sm = sm + NUM_W'(r_prod[i]);
            end
            r_num <= sm;
            r_den <= r_den8;
        end
    end

    // -------------------------------------------------------------- divider
    // restoring division, most significant quotient bit first
    for (genvar j = 0; j < QBITS; j++) begin : g_div
        localparam int B = QBITS - 1 - j;
        logic [NUM_W-1:0] rem_in;
        logic [QBITS-1:0] q_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] trial;

        if (j == 0) begin : g_first
            assign rem_in = r_num;
            assign q_in   = '0;
            assign den_in = r_den;
        end else begin : g_next
            assign rem_in = r_dv_rem[j-1];
            assign q_in   = r_dv_q[j-1];
            assign den_in = r_dv_den[j-1];
        end

        assign trial = NUM_W'(den_in) << B;

        always_ff @(posedge i_clk) begin
            if (rdy[ST_DIV+j]) begin
                r_dv_den[j] <= den_in;
                if (rem_in >= trial) begin
                    r_dv_rem[j] <= rem_in - trial;
                    r_dv_q[j]   <= q_in | (QBITS'(1) << B);
                end else begin
                    r_dv_rem[j] <= rem_in;
                    r_dv_q[j]   <= q_in;
                end
            end
        end
    end

endmodule

@@ rtl/fsi_checker.sv @@
// ----------------------------------------------------------------------------
// fsi_checker
// Port-level checks on the fuzzy speed inference unit.
// ----------------------------------------------------------------------------
module fsi_checker import fsi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [SPEED_W-1:0] i_out_speed
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_speed))
        else $error("result changed while stalled");

    // an empty or draining output never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input blocked with output free");

    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

endmodule

bind fuzzy_speed_inference_unit fsi_checker u_fsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_speed (o_out.speed)
);
